@@ rtl/sdae_pkg.sv @@
// ----------------------------------------------------------------------------
// sdae_pkg
// shared types and constants of the signed decimal ascii emitter
// ----------------------------------------------------------------------------
package sdae_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int CNT_W      = 4;
    localparam int PROD_W     = 64;
    localparam int RECIP_SHIFT = 35;
    localparam int QUOT_W     = PROD_W - RECIP_SHIFT;

    // floor(x / 10) == (x * RECIP) >> 35 for every 32-bit x
    localparam logic [VALUE_W-1:0] RECIP       = 32'hCCCC_CCCD;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_STORE,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic store;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic q_zero;
        logic neg;
        logic last_digit;
    } status_t;

endpackage

@@ rtl/sdae_ctrl.sv @@
// ----------------------------------------------------------------------------
// sdae_ctrl
// sequencer: divide-by-ten loop, then sign and digit emission
// ----------------------------------------------------------------------------
module sdae_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  sdae_pkg::status_t status,
    output sdae_pkg::cmd_t    cmd,
    output logic             busy
);

    sdae_pkg::state_t state_reg;
    sdae_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdae_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sdae_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = sdae_pkg::ST_MUL;
                end
            end
            sdae_pkg::ST_MUL:
            begin
                state_next = sdae_pkg::ST_STORE;
            end
            sdae_pkg::ST_STORE:
            begin
                priority if (!status.q_zero)
                begin
                    state_next = sdae_pkg::ST_MUL;
                end
                else if (status.neg)
                begin
                    state_next = sdae_pkg::ST_SIGN;
                end
                else
                begin
                    state_next = sdae_pkg::ST_DIGIT;
                end
            end
            sdae_pkg::ST_SIGN:
            begin
                state_next = sdae_pkg::ST_DIGIT;
            end
            sdae_pkg::ST_DIGIT:
            begin
                if (status.last_digit)
                begin
                    state_next = sdae_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sdae_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            sdae_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            sdae_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            sdae_pkg::ST_STORE:
            begin
                cmd.store = 1'b1;
            end
            sdae_pkg::ST_SIGN:
            begin
                cmd.emit_sign = 1'b1;
            end
            sdae_pkg::ST_DIGIT:
            begin
                cmd.emit_digit = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/sdae_datapath.sv @@
// ----------------------------------------------------------------------------
// sdae_datapath
// magnitude, reciprocal multiply, digit buffer and output beat register
// ----------------------------------------------------------------------------
module sdae_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [sdae_pkg::VALUE_W-1:0] value,
    input  sdae_pkg::cmd_t                      cmd,
    output sdae_pkg::status_t                   status,
    output logic        [sdae_pkg::CHAR_W-1:0]  character,
    output logic                                last,
    output logic                                valid
);

    logic [sdae_pkg::VALUE_W-1:0] mag_reg;
    logic                         neg_reg;
    logic [sdae_pkg::PROD_W-1:0]  prod_reg;
    logic [sdae_pkg::CNT_W-1:0]   cnt_reg;
    logic [sdae_pkg::DIGIT_W-1:0] digits_reg [sdae_pkg::NUM_DIGITS];
    logic [sdae_pkg::CHAR_W-1:0]  character_reg;
    logic                         last_reg;
    logic                         valid_reg;

    logic [sdae_pkg::VALUE_W-1:0] raw;
    logic [sdae_pkg::VALUE_W-1:0] abs_val;
    logic [sdae_pkg::VALUE_W-1:0] quot;
    logic [sdae_pkg::VALUE_W-1:0] rem_full;
    logic [sdae_pkg::CNT_W-1:0]   rd_idx;
    logic                         last_digit;

    assign raw      = value;
    assign abs_val  = raw[sdae_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;
    assign quot     = {{(sdae_pkg::VALUE_W-sdae_pkg::QUOT_W){1'b0}},
                       prod_reg[sdae_pkg::PROD_W-1:sdae_pkg::RECIP_SHIFT]};
    assign rem_full = mag_reg - (quot << 3) - (quot << 1);
    assign rd_idx   = cnt_reg - 1'b1;
    assign last_digit = (cnt_reg == sdae_pkg::CNT_W'(1));

    assign status.q_zero     = (quot == '0);
    assign status.neg        = neg_reg;
    assign status.last_digit = last_digit;

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= abs_val;
            neg_reg <= raw[sdae_pkg::VALUE_W-1];
        end
        else if (cmd.store)
        begin
            mag_reg <= quot;
        end
        if (cmd.mul)
        begin
            prod_reg <= mag_reg * sdae_pkg::RECIP;
        end
        if (cmd.store)
        begin
            digits_reg[cnt_reg] <= rem_full[sdae_pkg::DIGIT_W-1:0];
        end
        if (cmd.emit_sign)
        begin
            character_reg <= sdae_pkg::ASCII_MINUS;
            last_reg      <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            character_reg <= sdae_pkg::ASCII_ZERO
                             + {{(sdae_pkg::CHAR_W-sdae_pkg::DIGIT_W){1'b0}},
                                digits_reg[rd_idx]};
            last_reg      <= last_digit;
        end
    end

    // digit count and beat strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit_sign | cmd.emit_digit;
            priority if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.store)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cmd.emit_digit)
            begin
                cnt_reg <= rd_idx;
            end
        end
    end

    assign character = character_reg;
    assign last      = last_reg;
    assign valid     = valid_reg;

endmodule

@@ rtl/signed_decimal_ascii_emitter_top.sv @@
// ----------------------------------------------------------------------------
// signed_decimal_ascii_emitter_top
// converts a signed 32-bit value to its decimal ascii text, one char per beat
// ----------------------------------------------------------------------------
// usage:
//   input: a value is taken at a rising edge with start high and busy low.
//   output: each character is on character/last for one cycle with valid
//   high; last marks the final character of the value's text. a leading
//   '-' comes first for negative values, no leading zeros.
//   the magnitude is divided by ten through one reciprocal multiplier,
//   a multiply step, then a quotient and remainder step per digit; digits
//   go into a small buffer and are sent back out most significant first,
//   one per cycle.
//   the first character reaches the ports only after the whole divide
//   loop; busy stays high until the last digit has been emitted, so the
//   next value is not taken while the previous one is still in flight.
//   reset returns the sequencer to idle and drops valid; no clearing pass.
//   the receiver cannot stall: every beat is taken in its cycle.
// ----------------------------------------------------------------------------
module signed_decimal_ascii_emitter_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [sdae_pkg::VALUE_W-1:0] value,
    output logic                                busy,
    output logic        [sdae_pkg::CHAR_W-1:0]  character,
    output logic                                last,
    output logic                                valid
);

    sdae_pkg::cmd_t    cmd;
    sdae_pkg::status_t status;

    sdae_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sdae_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .character (character),
        .last      (last),
        .valid     (valid)
    );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for signed_decimal_ascii_emitter_top. Signed 32-bit values go in
// through the start/busy command port. A software model of the decimal
// conversion queues the ASCII characters and end-of-text flags that each
// value should produce. Every output beat is compared, in order, against
// that queue. The run covers directed extremes, random values of every digit
// length with bursts of sender idling, pauses that drain all expected text,
// and a final stretch of back-to-back commands.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_HALF    = 5;
    localparam int RESET_LEN   = 7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [sdae_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } glyph_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                start = 1'b0;
    logic signed [sdae_pkg::VALUE_W-1:0] value = '0;
    logic                                busy;
    logic [sdae_pkg::CHAR_W-1:0]         character;
    logic                                last;
    logic                                valid;

    glyph_t expected_text_q[$];
    int     error_count = 0;
    int     cycle_count = 0;
    bit     idle_enabled = 1'b1;

    signed_decimal_ascii_emitter_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .value     (value),
        .busy      (busy),
        .character (character),
        .last      (last),
        .valid     (valid)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // decimal text of a two's complement value, most significant char first
    function automatic void queue_decimal_text(
        input logic signed [sdae_pkg::VALUE_W-1:0] v);
        logic [sdae_pkg::VALUE_W-1:0] mag;
        logic [sdae_pkg::CHAR_W-1:0]  text[$];
        glyph_t                       g;
        mag = v[sdae_pkg::VALUE_W-1] ?
              (sdae_pkg::VALUE_W'(0) - sdae_pkg::VALUE_W'(v)) : sdae_pkg::VALUE_W'(v);
        do
        begin
            text.push_front(sdae_pkg::ASCII_ZERO + sdae_pkg::CHAR_W'(mag % 10));
            mag = mag / 10;
        end
        while (mag != 0);
        if (v[sdae_pkg::VALUE_W-1])
            text.push_front(sdae_pkg::ASCII_MINUS);
        foreach (text[i])
        begin
            g.ch   = text[i];
            g.last = (i == text.size() - 1);
            expected_text_q.push_back(g);
        end
    endfunction

    always @(posedge clk)
    begin : text_checker
        glyph_t g;
        if (rst_n && valid)
        begin
            if (expected_text_q.size() == 0)
                report_mismatch($sformatf("unexpected beat char=%0d last=%0b",
                                          character, last));
            else
            begin
                g = expected_text_q.pop_front();
                if (character !== g.ch)
                    report_mismatch($sformatf("char got %0d exp %0d", character, g.ch));
                if (last !== g.last)
                    report_mismatch($sformatf("last got %0b exp %0b (char %0d)",
                                              last, g.last, g.ch));
            end
        end
    end

    task automatic idle_burst(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_value(input logic signed [sdae_pkg::VALUE_W-1:0] v);
        if (idle_enabled && $urandom_range(2, 0) == 0)
            idle_burst($urandom_range(12, 1));
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        queue_decimal_text(v);
    endtask

    task automatic drain_text;
        start <= 1'b0;
        while (expected_text_q.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // value with a random digit count and sign, or fully random bits
    function automatic logic signed [sdae_pkg::VALUE_W-1:0] random_value();
        longint lo;
        longint hi;
        longint mag;
        int     d;
        if ($urandom_range(3, 0) == 0)
            return $urandom;
        d  = $urandom_range(10, 1);
        lo = 1;
        repeat (d - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (d == 1)
            lo = 0;
        if (hi > 64'd2147483647)
            hi = 64'd2147483647;
        mag = lo + longint'($urandom_range(32'(hi - lo), 0));
        if ($urandom_range(1, 0))
            return -sdae_pkg::VALUE_W'(mag);
        return sdae_pkg::VALUE_W'(mag);
    endfunction

    task automatic test_directed_extremes;
        logic signed [sdae_pkg::VALUE_W-1:0] vals[$];
        vals = {0, 1, -1, 9, -9, 10, -10, 99, -100,
                32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001,
                1000000000, 999999999, -1000000000,
                32'sh5555_5555, 32'shAAAA_AAAA};
        foreach (vals[i])
            send_value(vals[i]);
    endtask

    task automatic test_random_values;
        for (int chunk = 0; chunk < 6; chunk++)
        begin
            idle_enabled = 1'($urandom_range(1, 0));
            repeat (40) send_value(random_value());
        end
        idle_enabled = 1'b1;
    endtask

    task automatic test_drain_pause;
        repeat (4)
        begin
            repeat (5) send_value(random_value());
            drain_text();
        end
    endtask

    task automatic test_back_to_back;
        idle_enabled = 1'b0;
        repeat (60) send_value(random_value());
        start <= 1'b0;
    endtask

    initial
    begin
        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_random_values();
        test_drain_pause();
        test_back_to_back();

        drain_text();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/sdae_pkg.sv
rtl/sdae_ctrl.sv
rtl/sdae_datapath.sv
rtl/signed_decimal_ascii_emitter_top.sv
test/tb_top.sv
